FILE: hdl/kdst_pkg.sv
`default_nettype none
package kdst_pkg;

    localparam int unsigned TableEntriesDefault = 64;
    localparam logic [16:0] ProbOne  = 17'd65536;
    localparam logic [23:0] LmoprMax = 24'd16777215;

    localparam logic [1:0] ActUpdate = 2'd0;
    localparam logic [1:0] ActQuery  = 2'd1;
    localparam logic [1:0] ActDrop   = 2'd2;

    localparam logic [1:0] StHit    = 2'd0;
    localparam logic [1:0] StNew    = 2'd1;
    localparam logic [1:0] StFull   = 2'd2;
    localparam logic [1:0] StAbsent = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] seq_key;
        logic [16:0] prob;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] peak_prob;
        logic [16:0] mopr_value;
        logic [23:0] lmopr_value;
        logic [31:0] drop_total;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [16:0] peak;
        logic [16:0] mopr;
        logic [23:0] lmopr;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_WRITE
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/kdst_ram.sv
`default_nettype none
module kdst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/kdst_update.sv
`default_nettype none
module kdst_update (
    input  wire kdst_pkg::t_entry    i_base,
    input  wire logic [16:0]         i_prob,
    input  wire logic [33:0]         i_prod,
    input  wire logic [24:0]         i_lsum,
    output kdst_pkg::t_entry         o_entry
);
    import kdst_pkg::*;

    logic [33:0] rounded;
    logic [17:0] msum;

    always_comb begin
        rounded = i_prod + 34'd32768;
        msum    = {1'b0, i_base.mopr} + {1'b0, rounded[32:16]};
        o_entry       = i_base;
        o_entry.peak  = (i_base.peak < i_prob) ? i_prob : i_base.peak;
        o_entry.mopr  = (msum > {1'b0, ProbOne}) ? ProbOne : msum[16:0];
        o_entry.lmopr = (i_lsum > {1'b0, LmoprMax}) ? LmoprMax : i_lsum[23:0];
    end
endmodule
`default_nettype wire

FILE: hdl/keyed_delivery_stats_table.sv
// Each word is accepted in S_IDLE, checked against every entry in S_SCAN, combined in S_CALC and
// written back with its result registered in S_WRITE. No new word is taken until that result is
// registered; the full linear key scan over the single table RAM read port sets the pace, every
// operation scans the whole table. Reset: synchronous active low; afterwards a clearing pass
// zeroes the table RAM before the first word is taken. Drop counter resets to zero.
`default_nettype none
module keyed_delivery_stats_table #(
    parameter int unsigned TABLE_ENTRIES = kdst_pkg::TableEntriesDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire kdst_pkg::t_in_word  i_word,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output kdst_pkg::t_out_word      o_word
);
    import kdst_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    t_in_word r_in;
    logic [AW-1:0] r_addr;
    logic r_issue, r_chk;
    logic [AW-1:0] r_chk_idx;
    logic r_found, r_free;
    logic [AW-1:0] r_hit_idx, r_free_idx, r_slot;
    t_entry r_hit_data, r_base;
    logic [33:0] r_prod;
    logic [24:0] r_lsum;
    logic [31:0] r_drop;
    logic r_out_valid;
    t_out_word r_out;

    t_entry rdata, upd, base_c, wdata;
    logic we;
    logic [AW-1:0] waddr;
    logic [16:0] psat;
    logic [31:0] drop_next;
    t_out_word out_c;

    kdst_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    kdst_update u_upd (
        .i_base  (r_base),
        .i_prob  (r_in.prob),
        .i_prod  (r_prod),
        .i_lsum  (r_lsum),
        .o_entry (upd)
    );

    assign psat    = (i_word.prob > ProbOne) ? ProbOne : i_word.prob;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        base_c = r_hit_data;
        if (!r_found) begin
            base_c = '0;
            base_c.valid = 1'b1;
            base_c.key = r_in.seq_key;
        end
    end

    // result and write-back for the word in flight, and the clearing writes after reset
    always_comb begin
        out_c = '0;
        we = 1'b0;
        waddr = r_slot;
        wdata = r_base;
        drop_next = r_drop;
        unique case (r_in.action)
            ActUpdate, ActQuery: begin
                if (!r_found && !r_free) begin
                    out_c.status = StFull;
                end else begin
                    out_c.status = r_found ? StHit : StNew;
                    wdata = (r_in.action == ActUpdate) ? upd : r_base;
                    we = (r_in.action == ActUpdate) || !r_found;
                    out_c.peak_prob   = wdata.peak;
                    out_c.mopr_value  = wdata.mopr;
                    out_c.lmopr_value = wdata.lmopr;
                end
            end
            ActDrop: begin
                if (r_found) begin
                    out_c.status = StHit;
                    we = 1'b1;
                    wdata.valid = 1'b0;
                    drop_next = r_drop + 32'd1;
                end else begin
                    out_c.status = StAbsent;
                end
            end
            default: out_c.status = StHit;
        endcase
        out_c.drop_total = drop_next;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
            waddr = r_addr;
            wdata = '0;
        end else if (r_state != S_WRITE || (r_out_valid && !i_ready)) begin
            we = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == LastIdx) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_SCAN;
            S_SCAN:  if (r_chk && r_chk_idx == LastIdx) n_state = S_CALC;
            S_CALC:  n_state = S_WRITE;
            S_WRITE: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_addr <= (r_addr == LastIdx) ? '0 : r_addr + 1'b1;
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        r_found <= 1'b0;
                        r_free  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_chk     <= r_issue;
                    r_chk_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LastIdx) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_chk) begin
                        // first hit and lowest free slot win
                        if (rdata.valid && rdata.key == r_in.seq_key && !r_found) begin
                            r_found    <= 1'b1;
                            r_hit_idx  <= r_chk_idx;
                            r_hit_data <= rdata;
                        end
                        if (!rdata.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_chk_idx;
                        end
                    end
                end
                S_CALC: begin
                    r_chk <= 1'b0;
                end
                S_WRITE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_drop      <= drop_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= '{action: i_word.action, seq_key: i_word.seq_key, prob: psat};
        end
        if (r_state == S_CALC) begin
            r_base <= base_c;
            r_slot <= r_found ? r_hit_idx : r_free_idx;
            r_prod <= {17'd0, ProbOne - base_c.mopr} * {17'd0, r_in.prob};
            r_lsum <= {1'b0, base_c.lmopr} + {8'd0, r_in.prob};
        end
        if (r_state == S_WRITE && (!r_out_valid || i_ready)) begin
            r_out <= out_c;
        end
    end

    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_drop) |-> r_drop == $past(r_drop) + 32'd1)
        else $error("drop counter moved by other than one");

    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WRITE)
        else $error("result raised outside write-back");

    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !we)
        else $error("table written during scan");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;
    import kdst_pkg::*;

    localparam int Slots = 64;
    localparam int CycleLimit = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_word i_word = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_word o_word;

    keyed_delivery_stats_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic        slot_used [Slots];
    logic [31:0] slot_key  [Slots];
    logic [16:0] slot_peak [Slots];
    logic [16:0] slot_mopr [Slots];
    logic [23:0] slot_lmopr[Slots];
    logic [31:0] drops;

    t_out_word expected_words[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    logic [31:0] live_keys[$];

    function automatic int find_slot(logic [31:0] key);
        for (int s = 0; s < Slots; s++)
            if (slot_used[s] && slot_key[s] == key) return s;
        return -1;
    endfunction

    function automatic t_out_word apply_word(t_in_word w);
        t_out_word r;
        int s;
        logic [16:0] p;
        logic [33:0] inc;
        logic [24:0] sum;
        logic [17:0] m;
        r = '0;
        p = (w.prob > ProbOne) ? ProbOne : w.prob;
        if (w.action == ActUpdate || w.action == ActQuery) begin
            s = find_slot(w.seq_key);
            r.status = StHit;
            if (s < 0) begin
                for (int k = 0; k < Slots; k++)
                    if (!slot_used[k]) begin
                        s = k;
                        break;
                    end
                if (s < 0) r.status = StFull;
                else begin
                    r.status = StNew;
                    slot_used[s] = 1'b1;
                    slot_key[s] = w.seq_key;
                    slot_peak[s] = '0;
                    slot_mopr[s] = '0;
                    slot_lmopr[s] = '0;
                end
            end
            if (s >= 0) begin
                if (w.action == ActUpdate) begin
                    if (slot_peak[s] < p) slot_peak[s] = p;
                    inc = ((34'(ProbOne) - 34'(slot_mopr[s])) * 34'(p) + 34'd32768) >> 16;
                    m = 18'(slot_mopr[s]) + 18'(inc);
                    slot_mopr[s] = (m > 18'(ProbOne)) ? ProbOne : m[16:0];
                    sum = 25'(slot_lmopr[s]) + 25'(p);
                    slot_lmopr[s] = (sum > 25'(LmoprMax)) ? LmoprMax : sum[23:0];
                end
                r.peak_prob = slot_peak[s];
                r.mopr_value = slot_mopr[s];
                r.lmopr_value = slot_lmopr[s];
            end
        end else if (w.action == ActDrop) begin
            s = find_slot(w.seq_key);
            if (s < 0) r.status = StAbsent;
            else begin
                slot_used[s] = 1'b0;
                drops = drops + 1;
            end
        end
        r.drop_total = drops;
        return r;
    endfunction

    // valid stays up after an accept until the next word or an idle cycle replaces it
    task automatic send_word(logic [1:0] action, logic [31:0] key, logic [16:0] prob);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_word <= '{action: action, seq_key: key, prob: prob};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_words.push_back(apply_word('{action: action, seq_key: key, prob: prob}));
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", o_word);
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    if (o_word.status !== e.status || o_word.peak_prob !== e.peak_prob
                        || o_word.mopr_value !== e.mopr_value
                        || o_word.lmopr_value !== e.lmopr_value
                        || o_word.drop_total !== e.drop_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h got %h", e, o_word);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("keyed_delivery_stats_table test failed");
            $finish;
        end
    end

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return ProbOne;
            2: return 17'h1FFFF - 17'($urandom_range(65534));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(ActQuery, 32'd5, 17'd0);
        send_word(ActUpdate, 32'd5, 17'd0);
        send_word(ActUpdate, 32'd5, 17'd32768);
        send_word(ActUpdate, 32'd5, 17'h1FFFF);
        send_word(ActUpdate, 32'd5, ProbOne);
        send_word(ActQuery, 32'd5, 17'd123);
        send_word(ActUpdate, 32'hFFFF_FFFF, 17'd1);
        send_word(ActUpdate, 32'hFFFF_FFFF, 17'd1);
        send_word(ActUpdate, 32'h0, 17'h10001);
        send_word(ActDrop, 32'd5, 17'd0);
        send_word(ActDrop, 32'd5, 17'd0);
        send_word(2'd3, 32'hFFFF_FFFF, 17'h1FFFF);
        send_word(ActQuery, 32'h8000_0000, 17'h1FFFF);
        send_word(ActDrop, 32'hFFFF_FFFF, 17'd0);
        send_word(ActDrop, 32'h0, 17'd0);
        send_word(ActDrop, 32'h8000_0000, 17'd0);
    endtask

    // fill to capacity, hit full, then saturate lmopr on one key
    task automatic test_full_and_saturate();
        for (int k = 0; k < Slots + 2; k++) send_word(ActUpdate, 32'h100 + k, ProbOne);
        send_word(ActQuery, 32'hABCD, 17'd0);
        send_word(ActDrop, 32'h100, 17'd0);
        send_word(ActQuery, 32'hABCD, 17'd0);
        for (int k = 0; k < 260; k++) send_word(ActUpdate, 32'h101, ProbOne);
        for (int k = 0; k < Slots; k++) send_word(ActDrop, 32'h100 + k, 17'd0);
        send_word(ActDrop, 32'hABCD, 17'd0);
    endtask

    task automatic test_random(int n);
        logic [31:0] key;
        for (int k = 0; k < n; k++) begin
            // mostly reuse a pool of keys so hits, drops and fills happen
            if (live_keys.size() != 0 && $urandom_range(9) < 7)
                key = live_keys[$urandom_range(live_keys.size() - 1)];
            else begin
                key = $urandom;
                if (live_keys.size() < 80) live_keys.push_back(key);
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4: send_word(ActUpdate, key, rand_prob());
                5, 6: send_word(ActQuery, key, 17'($urandom));
                7, 8: send_word(ActDrop, key, 17'($urandom));
                default: send_word(2'd3, key, 17'($urandom));
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 1500;
        for (int k = 0; k < 20; k++) send_word(ActUpdate, 32'd77, rand_prob());
    endtask

    initial begin
        for (int s = 0; s < Slots; s++) slot_used[s] = 1'b0;
        drops = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_and_saturate();
        send_idle_pct = 15;
        recv_idle_pct = 77;
        test_random(300);
        test_backpressure();
        send_idle_pct = 77;
        recv_idle_pct = 15;
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        drain();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("keyed_delivery_stats_table test passed");
        else
            $display("keyed_delivery_stats_table test failed");
        $finish;
    end
endmodule
`default_nettype wire
